FILE: hdl/cvs_pkg.sv
// ---------------------------------------------------------------------------
// cvs_pkg - shared types and constants for the PCI VGA configuration space
// Transaction structs, lane control structs, fixed addresses and the
// reset contents of the 256-byte header.
// ---------------------------------------------------------------------------
`default_nettype none

package cvs_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned BankDepth = 256 / NumLanes;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [7:0] ADDR_CMD_LO    = 8'h04;
  localparam logic [7:0] ADDR_STS_LO    = 8'h06;
  localparam logic [7:0] ADDR_BAR0      = 8'h10;
  localparam logic [5:0] BAR0_ROW       = 6'h04;  // 0x10..0x13, one byte per bank
  localparam logic [7:0] ADDR_DROP_LO   = 8'h14;
  localparam logic [7:0] ADDR_ROM_BASE  = 8'h30;
  localparam logic [31:0] ROM_BASE_MASK = 32'hfffffc01;
  localparam logic [2:0] MAX_COUNT      = 3'd4;

  typedef struct packed {
    logic        func;
    logic [7:0]  byte_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bar_changed;
    logic        rom_base_written;
  } out_t;

  // Broadcast to every lane in the accept cycle
  typedef struct packed {
    logic        accept;
    logic        func;
    logic        drop;        // write into the BAR1..reserved window
    logic        vbe;
    logic [7:0]  byte_address;
    logic [31:0] write_data;  // already masked for a ROM base write
    logic [2:0]  byte_count;  // saturated to 1..4 (or 0)
  } lane_req_t;

  // bar_changed is valid in the accept cycle, word in the following one
  typedef struct packed {
    logic [31:0] word;
    logic        bar_changed;
  } lane_rsp_t;

  function automatic logic [7:0] reset_byte(input logic [7:0] a);
    logic [7:0] v;
    case (a)
      8'h00:   v = 8'h34;
      8'h01:   v = 8'h12;
      8'h02:   v = 8'h11;
      8'h03:   v = 8'h11;
      8'h04:   v = 8'h03;
      8'h07:   v = 8'h02;
      8'h0b:   v = 8'h03;
      8'h10:   v = 8'h08;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pci_vga_config_space_unit.sv
// ---------------------------------------------------------------------------
// pci_vga_config_space_unit - PCI VGA type 0 configuration header
// Four byte lanes serve 1..4 byte configuration reads and writes to the
// 256-byte header; a merge stage assembles read data and flags.
// ---------------------------------------------------------------------------
// Usage:
//   Input: a transaction (in_item) is taken on a rising edge with start high
//   and busy low. busy is always low, so one transaction per cycle is
//   sustained.
//   Output: out_valid is high for exactly one cycle, the cycle after the
//   transaction was taken, with out_item holding read data (zero for
//   writes) and the bar_changed / rom_base_written flags. The receiver
//   cannot stall; results are never held.
//   Throughput: 1 transaction per cycle. Each lane's bank
//   has one write and one read port; a transaction touches each lane at most
//   once, so the four banks together serve any 4-byte access without conflict.
//   Writes land at the accept edge, so a read in the very next cycle sees
//   them.
//   Configuration: cfg_data (VBE enable) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high.
//   Reset (rst_n low, synchronous): header returns to its reset contents at
//   once via per-byte written flags; VBE is enabled; no clearing sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module pci_vga_config_space_unit
  import cvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  // command channel
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  // result channel
  output logic      out_valid,
  output out_t      out_item,
  // configuration channel
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  logic      accept;
  logic      drop;
  logic      rom_hit;
  logic [2:0] cnt_sat;
  lane_req_t req;
  lane_rsp_t rsp [NumLanes];

  logic vbe_r;
  logic out_valid_r;
  logic bar_chg_r, bar_chg_nxt;
  logic rom_r;
  logic [31:0] rd_merge;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Writes starting in BAR1..reserved are discarded whole
  assign drop    = (in_item.byte_address >= ADDR_DROP_LO) &&
                   (in_item.byte_address < ADDR_ROM_BASE);
  assign rom_hit = (in_item.func == FUNC_WRITE) && (in_item.byte_address == ADDR_ROM_BASE);
  assign cnt_sat = (in_item.byte_count > MAX_COUNT) ? MAX_COUNT : in_item.byte_count;

  always_comb begin
    req.accept       = accept;
    req.func         = in_item.func;
    req.drop         = drop;
    req.vbe          = vbe_r;
    req.byte_address = in_item.byte_address;
    req.write_data   = rom_hit ? (in_item.write_data & ROM_BASE_MASK) : in_item.write_data;
    req.byte_count   = cnt_sat;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    cvs_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_id(2'(g)),
      .req    (req),
      .rsp    (rsp[g])
    );
  end

  // Merge: lanes drive disjoint byte positions, so OR is enough
  always_comb begin
    rd_merge    = '0;
    bar_chg_nxt = 1'b0;
    for (int k = 0; k < NumLanes; k++) begin
      rd_merge    = rd_merge | rsp[k].word;
      bar_chg_nxt = bar_chg_nxt | rsp[k].bar_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbe_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vbe_r <= cfg_data;
      end
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bar_chg_r <= bar_chg_nxt;
      rom_r     <= rom_hit && !drop;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_item.read_data        = rd_merge;
  assign out_item.bar_changed      = bar_chg_r;
  assign out_item.rom_base_written = rom_r;

  // A result only follows a transaction taken on the previous edge
  a_out_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start))
    else $error("result without a preceding transaction");

  // Writes return no read data
  a_write_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_item.func == FUNC_WRITE)) |-> (out_item.read_data == 32'h0))
    else $error("write transaction returned read data");

  // BAR0 can only change with VBE enabled
  a_bar_needs_vbe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bar_changed) |-> $past(vbe_r))
    else $error("BAR0 changed while VBE disabled");

  // A ROM base write lies within 0x30..0x33 and never reaches BAR0
  a_rom_not_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.rom_base_written) |-> !out_item.bar_changed)
    else $error("ROM base write flagged a BAR0 change");

endmodule

`default_nettype wire

FILE: hdl/cvs_ram.sv
// ---------------------------------------------------------------------------
// cvs_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cvs_lane.sv
// ---------------------------------------------------------------------------
// cvs_lane - one byte lane of the configuration space
// Owns every address with a[1:0] == lane_id: a 64-byte bank, its written
// flags and the matching BAR0 byte.
// ---------------------------------------------------------------------------
`default_nettype none

module cvs_lane
  import cvs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] lane_id,
  input  wire lane_req_t req,
  output lane_rsp_t      rsp
);

  localparam int unsigned RowW = $clog2(BankDepth);

  logic [1:0]      pos;      // byte index within the transaction
  logic [8:0]      full_addr;
  logic [7:0]      ba;
  logic [RowW-1:0] row;
  logic            hit, is_ro, is_bar, wr_ok, ram_we, bar_we, rd_go;
  logic [7:0]      nv, bar_nv, ram_q, rd_byte;

  logic [BankDepth-1:0] valid_r;
  logic [7:0]           bar_r;
  logic                 rd_en_r;
  logic                 src_ram_r;
  logic [7:0]           side_r;
  logic [1:0]           pos_r;
  logic [7:0]           side_nxt;
  logic                 src_ram_nxt;

  assign pos       = lane_id - req.byte_address[1:0];
  assign full_addr = {1'b0, req.byte_address} + {7'b0, pos};
  assign ba        = full_addr[7:0];
  assign row       = ba[7:2];
  assign hit       = ({1'b0, pos} < req.byte_count) && !full_addr[8];
  assign is_ro     = (ba == ADDR_CMD_LO) || (ba == ADDR_STS_LO);
  assign is_bar    = (row == BAR0_ROW);

  assign wr_ok  = req.accept && (req.func == FUNC_WRITE) && !req.drop && hit && !is_ro;
  assign ram_we = wr_ok && !is_bar;
  assign bar_we = wr_ok && is_bar && req.vbe;
  assign rd_go  = req.accept && (req.func == FUNC_READ) && hit;

  assign nv     = req.write_data[8*pos +: 8];
  // BAR0 low nibble is hardwired (memory, 32-bit, prefetch bits)
  assign bar_nv = (ba == ADDR_BAR0) ? {nv[7:4], bar_r[3:0]} : nv;

  cvs_ram #(
    .WIDTH(8),
    .DEPTH(BankDepth)
  ) u_bank (
    .clk  (clk),
    .we   (ram_we),
    .waddr(row),
    .wdata(nv),
    .re   (rd_go),
    .raddr(row),
    .rdata(ram_q)
  );

  // Read source: bank, BAR flop, or reset contents for untouched bytes
  always_comb begin
    src_ram_nxt = 1'b0;
    side_nxt    = reset_byte(ba);
    if (is_bar) begin
      side_nxt = req.vbe ? bar_r : 8'h00;
    end else if (!is_ro && valid_r[row]) begin
      src_ram_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      bar_r   <= reset_byte({BAR0_ROW, lane_id});
      rd_en_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[row] <= 1'b1;
      end
      if (bar_we) begin
        bar_r <= bar_nv;
      end
      rd_en_r <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      src_ram_r <= src_ram_nxt;
      side_r    <= side_nxt;
      pos_r     <= pos;
    end
  end

  assign rd_byte         = !rd_en_r ? 8'h00 : (src_ram_r ? ram_q : side_r);
  assign rsp.word        = {24'h0, rd_byte} << {pos_r, 3'b000};
  assign rsp.bar_changed = bar_we && (bar_nv != bar_r);

endmodule

`default_nettype wire
